FILE: hw/rtl/ptps_pkg.sv
package ptps_pkg;

   localparam int CoordW = 32;
   localparam int AngleW = 16;
   localparam int RangeW = 48;
   localparam int CorW = 34;
   localparam int CorSteps = 30;
   localparam int MulSteps = 14;

   localparam logic [RangeW-1:0] RangeReset = 48'd524288;
   localparam logic signed [CoordW-1:0] OneQ30 = 32'sd1073741824;
   localparam logic signed [CorW-1:0] CorOne = 34'sd1073741824;
   localparam logic signed [CorW-1:0] CorHalfTurn = 34'sd2147483648;
   localparam logic signed [CorW-1:0] CorX0 = 34'sd652032874;

   typedef enum logic {
      KIND_POINT = 1'b0,
      KIND_POSE = 1'b1
   } kind_type;

   typedef struct packed {
      logic [AngleW-1:0] yaw_angle;
      logic [AngleW-1:0] pitch_angle;
      logic [AngleW-1:0] roll_angle;
      logic signed [CoordW-1:0] coord_z;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] coord_x;
      kind_type kind;
   } item_type;

   typedef enum logic [2:0] {
      OP_SR = 3'd0,
      OP_CR = 3'd1,
      OP_SP = 3'd2,
      OP_CP = 3'd3,
      OP_SY = 3'd4,
      OP_CY = 3'd5,
      OP_SPSR = 3'd6,
      OP_SPCR = 3'd7
   } operand_type;

   function automatic logic signed [CorW-1:0] atan_turn(input logic [4:0] idx);
      logic signed [CorW-1:0] v;
      case (idx)
         5'd0: v = 34'sd536870912;
         5'd1: v = 34'sd316933406;
         5'd2: v = 34'sd167458907;
         5'd3: v = 34'sd85004756;
         5'd4: v = 34'sd42667331;
         5'd5: v = 34'sd21354465;
         5'd6: v = 34'sd10679838;
         5'd7: v = 34'sd5340245;
         5'd8: v = 34'sd2670163;
         5'd9: v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [CoordW-1:0] clamp_q30(input logic signed [CorW-1:0] v);
      logic signed [CoordW-1:0] r;
      if (v > CorOne) begin
         r = OneQ30;
      end else if (v < -CorOne) begin
         r = -OneQ30;
      end else begin
         r = v[CoordW-1:0];
      end
      return r;
   endfunction

   function automatic operand_type mul_opa(input logic [3:0] step);
      operand_type r;
      case (step)
         4'd0, 4'd1: r = OP_SP;
         4'd2, 4'd3, 4'd5, 4'd9, 4'd11: r = OP_CY;
         4'd4, 4'd6, 4'd7, 4'd8, 4'd10: r = OP_SY;
         4'd12, 4'd13: r = OP_CP;
         default: r = OP_SR;
      endcase
      return r;
   endfunction

   function automatic operand_type mul_opb(input logic [3:0] step);
      operand_type r;
      case (step)
         4'd0, 4'd6, 4'd11, 4'd12: r = OP_SR;
         4'd1, 4'd4, 4'd9, 4'd13: r = OP_CR;
         4'd2, 4'd7: r = OP_CP;
         4'd3, 4'd8: r = OP_SPSR;
         4'd5, 4'd10: r = OP_SPCR;
         default: r = OP_SR;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/ptps_queue.sv
module ptps_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  ptps_pkg::item_type in_item,
   output logic out_valid,
   input  logic out_pop,
   output ptps_pkg::item_type out_item
);
   import ptps_pkg::*;

   item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: hw/rtl/ptps_cordic.sv
module ptps_cordic (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [ptps_pkg::AngleW-1:0] angle,
   output logic done,
   output logic signed [ptps_pkg::CoordW-1:0] sin_val,
   output logic signed [ptps_pkg::CoordW-1:0] cos_val
);
   import ptps_pkg::*;

   logic signed [CorW-1:0] x_ff, x_in;
   logic signed [CorW-1:0] y_ff, y_in;
   logic signed [CorW-1:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic flip_ff, flip_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [CorW-1:0] z0;
   logic signed [CorW-1:0] x_sh;
   logic signed [CorW-1:0] y_sh;

   assign done = done_ff;
   assign cos_val = clamp_q30(flip_ff ? -x_ff : x_ff);
   assign sin_val = clamp_q30(flip_ff ? -y_ff : y_ff);

   always_comb begin
      z0 = {{(CorW-CoordW){angle[AngleW-1]}}, angle, {(CoordW-AngleW){1'b0}}};
      x_sh = x_ff >>> step_ff;
      y_sh = y_ff >>> step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = CorX0;
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
         if (z0 > CorOne) begin
            z_in = z0 - CorHalfTurn;
            flip_in = 1'b1;
         end else if (z0 < -CorOne) begin
            z_in = z0 + CorHalfTurn;
            flip_in = 1'b1;
         end else begin
            z_in = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_turn(step_ff);
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_turn(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CorSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      flip_ff <= flip_in;
   end

endmodule

FILE: hw/rtl/ptps_back.sv
module ptps_back (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   output logic item_pop,
   input  ptps_pkg::item_type item,
   input  logic csr_valid,
   input  logic [ptps_pkg::RangeW-1:0] csr_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [3*ptps_pkg::CoordW-1:0] rsp_data
);
   import ptps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQ = 7'b0000010,
      ST_DOT = 7'b0000100,
      ST_EMIT = 7'b0001000,
      ST_COR = 7'b0010000,
      ST_MUL = 7'b0100000,
      ST_MAT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [RangeW-1:0] thr_ff;
   logic signed [CoordW-1:0] rot_ff [9];
   logic signed [CoordW-1:0] trans_ff [3];
   logic signed [CoordW-1:0] trig_ff [6];
   logic signed [CoordW-1:0] pr_ff [MulSteps];
   logic signed [CoordW-1:0] res_ff [3];
   item_type cur_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] ang_ff, ang_in;
   logic phase_ff, phase_in;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0] sq_ff, sq_in;
   logic rsp_valid_ff;
   logic [3*CoordW-1:0] rsp_data_ff;

   logic signed [CoordW-1:0] op_a;
   logic signed [CoordW-1:0] op_b;
   logic signed [CoordW-1:0] pt [3];
   logic signed [63:0] acc_sum;
   logic signed [63:0] acc_rnd;
   logic signed [35:0] row_val;
   logic signed [CoordW-1:0] row_sat;
   logic signed [63:0] mul_rnd;
   logic [63:0] sq_sum;
   logic cor_start;
   logic cor_done;
   logic signed [CoordW-1:0] cor_sin;
   logic signed [CoordW-1:0] cor_cos;
   logic [AngleW-1:0] cor_angle;
   logic out_free;
   logic take;
   logic mul_phase;
   logic row_phase;
   logic [3:0] rot_idx;

   ptps_cordic u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cor_start),
      .angle(cor_angle),
      .done(cor_done),
      .sin_val(cor_sin),
      .cos_val(cor_cos)
   );

   function automatic logic signed [CoordW-1:0] pick(input operand_type code,
         input logic signed [CoordW-1:0] t0, input logic signed [CoordW-1:0] t1,
         input logic signed [CoordW-1:0] t2, input logic signed [CoordW-1:0] t3,
         input logic signed [CoordW-1:0] t4, input logic signed [CoordW-1:0] t5,
         input logic signed [CoordW-1:0] t6, input logic signed [CoordW-1:0] t7);
      logic signed [CoordW-1:0] r;
      case (code)
         OP_SR: r = t0;
         OP_CR: r = t1;
         OP_SP: r = t2;
         OP_CP: r = t3;
         OP_SY: r = t4;
         OP_CY: r = t5;
         OP_SPSR: r = t6;
         OP_SPCR: r = t7;
         default: r = t0;
      endcase
      return r;
   endfunction

   function automatic logic signed [CoordW-1:0] clamp33(input logic signed [32:0] v);
      return clamp_q30({{(CorW-33){v[32]}}, v});
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take = (state_ff == ST_IDLE) && item_valid;
   assign item_pop = take;
   assign pt[0] = cur_ff.coord_x;
   assign pt[1] = cur_ff.coord_y;
   assign pt[2] = cur_ff.coord_z;
   assign cor_start = (take && item.kind == KIND_POSE)
      || (state_ff == ST_COR && cor_done && ang_ff != 2'd2);
   assign mul_phase = (state_ff == ST_MUL) && phase_ff;
   assign row_phase = (state_ff == ST_DOT) && phase_ff && cnt_ff == 4'd2;

   always_comb begin
      if (take) begin
         cor_angle = item.roll_angle;
      end else if (ang_ff == 2'd0) begin
         cor_angle = cur_ff.pitch_angle;
      end else begin
         cor_angle = cur_ff.yaw_angle;
      end
   end

   always_comb begin
      rot_idx = 4'({2'b00, row_ff} * 4'd3 + cnt_ff);
      op_a = pt[cnt_ff[1:0]];
      op_b = pt[cnt_ff[1:0]];
      if (state_ff == ST_DOT) begin
         op_a = rot_ff[rot_idx];
      end else if (state_ff == ST_MUL) begin
         op_a = pick(mul_opa(cnt_ff), trig_ff[0], trig_ff[1], trig_ff[2], trig_ff[3],
            trig_ff[4], trig_ff[5], pr_ff[0], pr_ff[1]);
         op_b = pick(mul_opb(cnt_ff), trig_ff[0], trig_ff[1], trig_ff[2], trig_ff[3],
            trig_ff[4], trig_ff[5], pr_ff[0], pr_ff[1]);
      end
      sq_sum = sq_ff + 64'(prod_ff);
      acc_sum = acc_ff + prod_ff;
      acc_rnd = acc_sum + 64'sd536870912;
      row_val = 36'($signed(acc_rnd[63:30])) + 36'(trans_ff[row_ff]);
      if (row_val > 36'sd2147483647) begin
         row_sat = 32'sh7fffffff;
      end else if (row_val < -36'sd2147483648) begin
         row_sat = 32'sh80000000;
      end else begin
         row_sat = row_val[CoordW-1:0];
      end
      mul_rnd = prod_ff + 64'sd536870912;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      row_in = row_ff;
      ang_in = ang_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      sq_in = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               cnt_in = '0;
               row_in = '0;
               ang_in = '0;
               phase_in = 1'b0;
               acc_in = '0;
               sq_in = '0;
               state_in = (item.kind == KIND_POSE) ? ST_COR : ST_SQ;
            end
         end
         ST_SQ: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               sq_in = sq_sum;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd2) begin
                  cnt_in = '0;
                  state_in = (sq_sum > {thr_ff, 16'h0000}) ? ST_DOT : ST_IDLE;
               end
            end
         end
         ST_DOT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_in = acc_sum;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd2) begin
                  acc_in = '0;
                  cnt_in = '0;
                  row_in = row_ff + 2'd1;
                  if (row_ff == 2'd2) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_COR: begin
            if (cor_done) begin
               ang_in = ang_ff + 2'd1;
               if (ang_ff == 2'd2) begin
                  cnt_in = '0;
                  phase_in = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'(MulSteps - 1)) begin
                  state_in = ST_MAT;
               end
            end
         end
         ST_MAT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff <= RangeReset;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= (k % 4 == 0) ? OneQ30 : '0;
         end
         for (int k = 0; k < 3; k++) begin
            trans_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MAT) begin
            rot_ff[0] <= pr_ff[2];
            rot_ff[1] <= clamp33(33'(pr_ff[3]) - 33'(pr_ff[4]));
            rot_ff[2] <= clamp33(33'(pr_ff[5]) + 33'(pr_ff[6]));
            rot_ff[3] <= pr_ff[7];
            rot_ff[4] <= clamp33(33'(pr_ff[8]) + 33'(pr_ff[9]));
            rot_ff[5] <= clamp33(33'(pr_ff[10]) - 33'(pr_ff[11]));
            rot_ff[6] <= clamp33(-33'(trig_ff[2]));
            rot_ff[7] <= pr_ff[12];
            rot_ff[8] <= pr_ff[13];
            trans_ff[0] <= cur_ff.coord_x;
            trans_ff[1] <= cur_ff.coord_y;
            trans_ff[2] <= cur_ff.coord_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      row_ff <= row_in;
      ang_ff <= ang_in;
      phase_ff <= phase_in;
      acc_ff <= acc_in;
      sq_ff <= sq_in;
      prod_ff <= 64'(op_a) * 64'(op_b);
      if (take) begin
         cur_ff <= item;
      end
      if (state_ff == ST_COR && cor_done) begin
         trig_ff[{ang_ff, 1'b0}] <= cor_sin;
         trig_ff[{ang_ff, 1'b1}] <= cor_cos;
      end
      if (mul_phase) begin
         pr_ff[cnt_ff] <= mul_rnd[61:30];
      end
      if (row_phase) begin
         res_ff[row_ff] <= row_sat;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
      end
   end

endmodule

FILE: hw/rtl/pose_transform_point_stream.sv
// A point transfer occupies the sequencer for the norm and, when kept, also for the 3x3 product;
// one shared 32x32 multiplier serves the norm, the 3x3 product and the pose products.
// A pose transfer takes three 30-step CORDIC runs and 14 products.
// A two-entry queue sits in front.
// Synchronous active-high reset loads the identity rotation, zero translation and a
// threshold of 8.0, and empties the queue and the output register.
module pose_transform_point_stream (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coord_x, coord_y, coord_z, roll_angle, pitch_angle, yaw_angle
   input  logic [143:0] req_tdata,
   // kind
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // world_x, world_y, world_z
   output logic [95:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ptps_pkg::RangeW-1:0] csr_data
);
   import ptps_pkg::*;

   item_type in_item;
   item_type q_item;
   logic q_valid;
   logic q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      in_item.kind = kind_type'(req_tuser);
      in_item.coord_x = req_tdata[31:0];
      in_item.coord_y = req_tdata[63:32];
      in_item.coord_z = req_tdata[95:64];
      in_item.roll_angle = req_tdata[111:96];
      in_item.pitch_angle = req_tdata[127:112];
      in_item.yaw_angle = req_tdata[143:128];
   end

   ptps_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_item(in_item),
      .out_valid(q_valid),
      .out_pop(q_pop),
      .out_item(q_item)
   );

   ptps_back u_back (
      .clock(clock),
      .reset(reset),
      .item_valid(q_valid),
      .item_pop(q_pop),
      .item(q_item),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_data(rsp_tdata)
   );

endmodule
